// ----- hdl/diamond_square_heightmap_top_defines.svh -----
// assertion helpers for the height map generator
`ifndef DIAMOND_SQUARE_HEIGHTMAP_TOP_DEFINES_SVH
`define DIAMOND_SQUARE_HEIGHTMAP_TOP_DEFINES_SVH

// same-cycle implication
`define DSH_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dsh assertion failed");

// next-cycle implication
`define DSH_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dsh assertion failed");

`endif

// ----- hdl/dsh_pkg.sv -----
`timescale 1ns / 1ps

package dsh_pkg;

  localparam int SIDE_LOG2_MAX = 8;
  localparam int COORD_W       = SIDE_LOG2_MAX + 1;
  localparam int MAX_SIDE      = (1 << SIDE_LOG2_MAX) + 1;
  localparam int MAP_DEPTH     = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W        = $clog2(MAP_DEPTH);
  localparam int SUM_W         = 10;
  localparam int MUL_A_W       = 16;
  localparam int MUL_B_W       = 10;
  localparam int MUL_W         = MUL_A_W + MUL_B_W;
  localparam int RECIP3_SH     = 11;
  localparam logic [MUL_B_W-1:0] RECIP3 = MUL_B_W'(683);

  localparam logic REG_SIDE_LOG2    = 1'b0;
  localparam logic REG_START_SPREAD = 1'b1;

  typedef enum logic [1:0] {
    PH_CORNER,
    PH_DIAMOND,
    PH_SQUARE
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_MEAN,
    ST_WRITE
  } seq_t;

  // row-major address, row pitch is MAX_SIDE = 2^SIDE_LOG2_MAX + 1
  function automatic logic [ADDR_W-1:0] map_addr(input logic [COORD_W-1:0] x,
                                                 input logic [COORD_W-1:0] y);
    logic [ADDR_W-1:0] row;
    row = ADDR_W'({y, {SIDE_LOG2_MAX{1'b0}}}) + ADDR_W'(y);
    return row + ADDR_W'(x);
  endfunction

endpackage

// ----- hdl/dsh_in_if.sv -----
`timescale 1ns / 1ps

interface dsh_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink (input valid, input random_word, output ready);
endinterface

// ----- hdl/dsh_out_if.sv -----
`timescale 1ns / 1ps

interface dsh_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] x_pos;
  logic [8:0] y_pos;
  logic [7:0] height;
  logic       last;

  modport source (output valid, output x_pos, output y_pos, output height, output last,
                  input ready);
  modport sink (input valid, input x_pos, input y_pos, input height, input last,
                output ready);
endinterface

// ----- hdl/diamond_square_heightmap_top.sv -----
`timescale 1ns / 1ps
// Diamond-square height map generator. Each accepted request carries one random word and
// yields one map point (column, row, height, last flag); the four corners come first, then
// each level's diamond and square passes, and the point flagged last completes the map so
// the next request starts a new one with the side and spread latched at that moment. A
// corner goes from acceptance straight to the write step; every other point takes four
// neighbour reads through the single-port 66049 x 8 map memory, a step to collect the
// last read and form the offset product, a step for the mean on the same shared multiplier,
// and a step to clamp, write back and load the output register. The next request is taken
// while a finished point still waits in the output register; the write step waits only
// when that register is still full.
`include "diamond_square_heightmap_top_defines.svh"

module diamond_square_heightmap_top (
  input  logic             clk,
  input  logic             rst_n,
  dsh_in_if.sink           in_req,
  dsh_out_if.source        out_req,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [2:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int CW = dsh_pkg::COORD_W;
  localparam int AW = dsh_pkg::ADDR_W;

  dsh_pkg::seq_t   state_r, state_nxt;
  dsh_pkg::phase_t phase_r;

  logic [CW-1:0] cx_r, cy_r, step_r;
  logic [7:0]    spread_r;
  logic [3:0]    map_log2_r;
  logic [15:0]   word_r;
  logic [1:0]    nb_idx_r;
  logic          rd_pend_r;
  logic [dsh_pkg::SUM_W-1:0] sum_r;
  logic [2:0]    cnt_r;
  logic [8:0]    prod_hi_r;
  logic [7:0]    mean_r;
  logic signed [9:0] off_r;

  logic [3:0]    side_log2_r;
  logic [7:0]    start_spread_r;

  logic [7:0]    map_mem [dsh_pkg::MAP_DEPTH];
  logic [7:0]    mem_q;

  logic          out_valid_r, out_last_r;
  logic [8:0]    out_x_r, out_y_r;
  logic [7:0]    out_h_r;

  // control
  logic in_fire, out_free, wr_go, rd_en, map_start, cfg_we;

  // neighbour addressing
  logic [CW-1:0] n_side, half;
  logic [CW:0]   xm, xp, ym, yp;
  logic          x_lo_ok, x_hi_ok, y_lo_ok, y_hi_ok;
  logic [CW-1:0] nb_x, nb_y;
  logic          nb_ok;
  logic [AW-1:0] mem_addr;

  // shared multiplier
  logic [dsh_pkg::MUL_A_W-1:0] mul_a;
  logic [dsh_pkg::MUL_B_W-1:0] mul_b;
  logic [dsh_pkg::MUL_W-1:0]   mul_p;

  // point value and cursor advance
  logic signed [10:0] pt_sum;
  logic [7:0]    pt_val;
  logic [7:0]    mean_nxt;
  logic [3:0]    log2_sat;
  logic [CW:0]   adv_x_sum, adv_y_sum;
  logic [CW-1:0] adv_cx, adv_cy, adv_step, adv_half;
  logic [7:0]    adv_spread;
  dsh_pkg::phase_t adv_phase;
  logic          adv_last;

  assign in_fire   = in_req.valid && in_req.ready;
  assign out_free  = !out_valid_r || out_req.ready;
  assign map_start = (phase_r == dsh_pkg::PH_CORNER) && (cx_r == '0) && (cy_r == '0);
  assign n_side    = CW'(1) << map_log2_r;
  assign half      = step_r >> 1;
  assign cfg_we    = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_log2_r    <= 4'd8;
      start_spread_r <= 8'd128;
    end else if (cfg_we) begin
      unique case (cfg_paddr[2])
        dsh_pkg::REG_SIDE_LOG2:    side_log2_r    <= cfg_pwdata[3:0];
        dsh_pkg::REG_START_SPREAD: start_spread_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      dsh_pkg::REG_SIDE_LOG2:    cfg_prdata = {28'd0, side_log2_r};
      dsh_pkg::REG_START_SPREAD: cfg_prdata = {24'd0, start_spread_r};
      default:                   cfg_prdata = '0;
    endcase
  end

  always_comb begin
    if (side_log2_r == 4'd0) begin
      log2_sat = 4'd1;
    end else if (side_log2_r > 4'(dsh_pkg::SIDE_LOG2_MAX)) begin
      log2_sat = 4'(dsh_pkg::SIDE_LOG2_MAX);
    end else begin
      log2_sat = side_log2_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dsh_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (phase_r == dsh_pkg::PH_CORNER) ? dsh_pkg::ST_WRITE : dsh_pkg::ST_READ;
        end
      end
      dsh_pkg::ST_READ: begin
        if (nb_idx_r == 2'd3) begin
          state_nxt = dsh_pkg::ST_SUM;
        end
      end
      dsh_pkg::ST_SUM:  state_nxt = dsh_pkg::ST_MEAN;
      dsh_pkg::ST_MEAN: state_nxt = dsh_pkg::ST_WRITE;
      dsh_pkg::ST_WRITE: begin
        if (out_free) begin
          state_nxt = dsh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dsh_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_req.ready = 1'b0;
    rd_en        = 1'b0;
    wr_go        = 1'b0;
    mul_a        = word_r;
    mul_b        = {1'b0, spread_r, 1'b1};
    unique case (state_r)
      dsh_pkg::ST_IDLE:  in_req.ready = 1'b1;
      dsh_pkg::ST_READ:  rd_en = nb_ok;
      dsh_pkg::ST_SUM: begin
        mul_a = word_r;
        mul_b = {1'b0, spread_r, 1'b1};
      end
      dsh_pkg::ST_MEAN: begin
        mul_a = dsh_pkg::MUL_A_W'(sum_r);
        mul_b = dsh_pkg::RECIP3;
      end
      dsh_pkg::ST_WRITE: wr_go = out_free;
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // neighbour selection
  assign xm = {1'b0, cx_r} - {1'b0, half};
  assign xp = {1'b0, cx_r} + {1'b0, half};
  assign ym = {1'b0, cy_r} - {1'b0, half};
  assign yp = {1'b0, cy_r} + {1'b0, half};
  assign x_lo_ok = cx_r >= half;
  assign y_lo_ok = cy_r >= half;
  assign x_hi_ok = xp <= {1'b0, n_side};
  assign y_hi_ok = yp <= {1'b0, n_side};

  always_comb begin
    nb_x  = cx_r;
    nb_y  = cy_r;
    nb_ok = 1'b0;
    if (phase_r == dsh_pkg::PH_DIAMOND) begin
      case (nb_idx_r)
        2'd0: begin nb_x = xm[CW-1:0]; nb_y = ym[CW-1:0]; nb_ok = x_lo_ok && y_lo_ok; end
        2'd1: begin nb_x = xp[CW-1:0]; nb_y = ym[CW-1:0]; nb_ok = x_hi_ok && y_lo_ok; end
        2'd2: begin nb_x = xm[CW-1:0]; nb_y = yp[CW-1:0]; nb_ok = x_lo_ok && y_hi_ok; end
        default: begin nb_x = xp[CW-1:0]; nb_y = yp[CW-1:0]; nb_ok = x_hi_ok && y_hi_ok; end
      endcase
    end else begin
      case (nb_idx_r)
        2'd0: begin nb_y = ym[CW-1:0]; nb_ok = y_lo_ok; end
        2'd1: begin nb_x = xm[CW-1:0]; nb_ok = x_lo_ok; end
        2'd2: begin nb_y = yp[CW-1:0]; nb_ok = y_hi_ok; end
        default: begin nb_x = xp[CW-1:0]; nb_ok = x_hi_ok; end
      endcase
    end
  end

  assign mem_addr = wr_go ? dsh_pkg::map_addr(cx_r, cy_r) : dsh_pkg::map_addr(nb_x, nb_y);

  // map memory
  always_ff @(posedge clk) begin
    if (wr_go) begin
      map_mem[mem_addr] <= pt_val;
    end else if (rd_en) begin
      mem_q <= map_mem[mem_addr];
    end
  end

  // mean of the collected neighbours
  always_comb begin
    case (cnt_r)
      3'd1:    mean_nxt = sum_r[7:0];
      3'd2:    mean_nxt = sum_r[8:1];
      3'd3:    mean_nxt = mul_p[dsh_pkg::RECIP3_SH +: 8];
      3'd4:    mean_nxt = sum_r[9:2];
      default: mean_nxt = 8'd0;
    endcase
  end

  // clamp point value
  always_comb begin
    pt_sum = $signed({3'b000, mean_r}) + $signed({off_r[9], off_r});
    if (phase_r == dsh_pkg::PH_CORNER) begin
      pt_val = word_r[15:8];
    end else if (pt_sum < 0) begin
      pt_val = 8'd0;
    end else if (pt_sum > 11'sd255) begin
      pt_val = 8'd255;
    end else begin
      pt_val = pt_sum[7:0];
    end
  end

  // scan order
  always_comb begin
    adv_cx     = cx_r;
    adv_cy     = cy_r;
    adv_step   = step_r;
    adv_spread = spread_r;
    adv_phase  = phase_r;
    adv_last   = 1'b0;
    adv_half   = step_r >> 2;
    adv_x_sum  = {1'b0, cx_r} + {1'b0, step_r};
    adv_y_sum  = {1'b0, cy_r} + {1'b0, step_r};
    if (phase_r == dsh_pkg::PH_CORNER) begin
      if (cx_r == '0 && cy_r == '0) begin
        adv_cx = n_side;
      end else if (cy_r == '0) begin
        adv_cx = '0;
        adv_cy = n_side;
      end else if (cx_r == '0) begin
        adv_cx = n_side;
      end else begin
        adv_step  = n_side;
        adv_phase = dsh_pkg::PH_DIAMOND;
        adv_cx    = n_side >> 1;
        adv_cy    = n_side >> 1;
      end
    end else if (adv_x_sum > {1'b0, n_side}) begin
      if (phase_r == dsh_pkg::PH_DIAMOND) begin
        adv_cx = half;
        if (adv_y_sum > {1'b0, n_side}) begin
          adv_phase = dsh_pkg::PH_SQUARE;
          adv_cy    = '0;
        end else begin
          adv_cy = adv_y_sum[CW-1:0];
        end
      end else begin
        adv_y_sum = {1'b0, cy_r} + {1'b0, half};
        if (adv_y_sum > {1'b0, n_side}) begin
          adv_step   = half;
          adv_spread = spread_r >> 1;
          if (half > CW'(1)) begin
            adv_phase = dsh_pkg::PH_DIAMOND;
            adv_cx    = adv_half;
            adv_cy    = adv_half;
          end else begin
            adv_phase = dsh_pkg::PH_CORNER;
            adv_cx    = '0;
            adv_cy    = '0;
            adv_last  = 1'b1;
          end
        end else begin
          adv_cy = adv_y_sum[CW-1:0];
          adv_cx = ((adv_y_sum[CW-1:0] & (step_r - CW'(1))) == '0) ? half : '0;
        end
      end
    end else begin
      adv_cx = adv_x_sum[CW-1:0];
    end
  end

  // sequencer and map state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= dsh_pkg::ST_IDLE;
      phase_r    <= dsh_pkg::PH_CORNER;
      cx_r       <= '0;
      cy_r       <= '0;
      step_r     <= '0;
      spread_r   <= '0;
      map_log2_r <= 4'd1;
      nb_idx_r   <= '0;
      rd_pend_r  <= 1'b0;
      cnt_r      <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_en;
      if (in_fire) begin
        nb_idx_r <= '0;
        cnt_r    <= '0;
        if (map_start) begin
          map_log2_r <= log2_sat;
          spread_r   <= start_spread_r;
        end
      end
      if (state_r == dsh_pkg::ST_READ) begin
        nb_idx_r <= nb_idx_r + 2'd1;
      end
      if (rd_pend_r) begin
        cnt_r <= cnt_r + 3'd1;
      end
      if (wr_go) begin
        cx_r     <= adv_cx;
        cy_r     <= adv_cy;
        step_r   <= adv_step;
        spread_r <= adv_spread;
        phase_r  <= adv_phase;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      word_r <= in_req.random_word;
      sum_r  <= '0;
    end else if (rd_pend_r) begin
      sum_r <= sum_r + dsh_pkg::SUM_W'(mem_q);
    end
    if (state_r == dsh_pkg::ST_SUM) begin
      prod_hi_r <= mul_p[24:16];
    end
    if (state_r == dsh_pkg::ST_MEAN) begin
      mean_r <= mean_nxt;
      off_r  <= $signed({1'b0, prod_hi_r}) - $signed({2'b00, spread_r});
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wr_go) begin
      out_valid_r <= 1'b1;
    end else if (out_req.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_go) begin
      out_x_r    <= cx_r;
      out_y_r    <= cy_r;
      out_h_r    <= pt_val;
      out_last_r <= adv_last;
    end
  end

  assign out_req.valid  = out_valid_r;
  assign out_req.x_pos  = out_x_r;
  assign out_req.y_pos  = out_y_r;
  assign out_req.height = out_h_r;
  assign out_req.last   = out_last_r;

  `DSH_ASSERT_NEXT(a_accept_leaves_idle, in_fire, state_r != dsh_pkg::ST_IDLE)
  `DSH_ASSERT_IMPL(a_mean_has_neighbour, state_r == dsh_pkg::ST_MEAN, cnt_r != 3'd0)
  `DSH_ASSERT_NEXT(a_last_rewinds, wr_go && adv_last, map_start && out_valid_r)

endmodule

// ----- bench/tb_diamond_square_heightmap_top.sv -----
`timescale 1ns / 1ps

module tb_diamond_square_heightmap_top;

  typedef struct packed {
    logic [8:0] x;
    logic [8:0] y;
    logic [7:0] h;
    logic       last;
  } point_t;

  typedef enum logic [1:0] {
    ROW_POINT,
    ROW_SIDE,
    ROW_SPREAD
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] val;
    logic        typed;
    point_t      pt;
  } plan_row_t;

  localparam int PLAN_ROWS     = 22;
  localparam int RANDOM_ITEMS  = 700;
  localparam int BIG_MAP_ITEMS = 150;
  localparam int SETTLE_CYCLES = 10;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        sink_ready  = 1'b0;

  dsh_in_if  in_ch ();
  dsh_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  diamond_square_heightmap_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_ch),
    .out_req     (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // map generator state
  logic [7:0]       map_mem [dsh_pkg::MAP_DEPTH];
  dsh_pkg::phase_t  scan_phase = dsh_pkg::PH_CORNER;
  int         col        = 0;
  int         row        = 0;
  int         lvl_step   = 0;
  int         cur_spread = 0;
  int         map_k      = 1;
  int         cfg_side   = 8;
  int         cfg_spread = 128;

  point_t     pending_points [$];
  point_t     head;
  int         errors          = 0;
  int         items_sent      = 0;
  bit         steady_flow     = 1'b0;
  bit         steady_sink     = 1'b0;
  int         stall_left      = 0;
  int         sink_mode_left  = 0;

  function automatic point_t next_point(input logic [15:0] w);
    point_t p;
    int     n, d, half, sum, cnt, nx, ny, off, v, k;
    int     dx [4];
    int     dy [4];
    bit     diamond;
    if (scan_phase == dsh_pkg::PH_CORNER && col == 0 && row == 0) begin
      map_k = (cfg_side < 1) ? 1 :
              (cfg_side > dsh_pkg::SIDE_LOG2_MAX) ? dsh_pkg::SIDE_LOG2_MAX : cfg_side;
      cur_spread = cfg_spread;
    end
    n = 1 << map_k;
    p.x = 9'(col);
    p.y = 9'(row);
    p.last = 1'b0;
    if (scan_phase == dsh_pkg::PH_CORNER) begin
      p.h = w[15:8];
      map_mem[row * dsh_pkg::MAX_SIDE + col] = p.h;
      if (col == 0 && row == 0) begin
        col = n;
      end else if (row == 0) begin
        col = 0;
        row = n;
      end else if (col == 0) begin
        col = n;
      end else begin
        lvl_step = n;
        scan_phase = dsh_pkg::PH_DIAMOND;
        col = n >> 1;
        row = n >> 1;
      end
    end else begin
      diamond = (scan_phase == dsh_pkg::PH_DIAMOND);
      d = lvl_step >> 1;
      if (diamond) begin
        dx = '{-d, d, -d, d};
        dy = '{-d, -d, d, d};
      end else begin
        dx = '{0, -d, 0, d};
        dy = '{-d, 0, d, 0};
      end
      sum = 0;
      cnt = 0;
      for (k = 0; k < 4; k++) begin
        nx = col + dx[k];
        ny = row + dy[k];
        if (nx >= 0 && ny >= 0 && nx <= n && ny <= n) begin
          sum += map_mem[ny * dsh_pkg::MAX_SIDE + nx];
          cnt++;
        end
      end
      off = ((int'(w) * (2 * cur_spread + 1)) >> 16) - cur_spread;
      v = ((cnt != 0) ? sum / cnt : 0) + off;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      p.h = 8'(v);
      map_mem[row * dsh_pkg::MAX_SIDE + col] = p.h;
      half = lvl_step >> 1;
      col += lvl_step;
      if (col > n) begin
        if (diamond) begin
          col = half;
          row += lvl_step;
          if (row > n) begin
            scan_phase = dsh_pkg::PH_SQUARE;
            row = 0;
            col = half;
          end
        end else begin
          row += half;
          if (row > n) begin
            lvl_step >>= 1;
            cur_spread >>= 1;
            if (lvl_step > 1) begin
              scan_phase = dsh_pkg::PH_DIAMOND;
              col = lvl_step >> 1;
              row = lvl_step >> 1;
            end else begin
              scan_phase = dsh_pkg::PH_CORNER;
              col = 0;
              row = 0;
              p.last = 1'b1;
            end
          end else begin
            col = ((row & (lvl_step - 1)) == 0) ? half : 0;
          end
        end
      end
    end
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'h0000;
    if (r < 10) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic int pick_side();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 0;
    if (r < 36) return 1;
    if (r < 64) return 2;
    if (r < 88) return 3;
    return 4;
  endfunction

  function automatic int pick_spread();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 0;
    if (r < 40) return 255;
    return $urandom_range(0, 255);
  endfunction

  function automatic logic [31:0] field_mask(input logic idx);
    return (idx == dsh_pkg::REG_SIDE_LOG2) ? 32'h0000_000F : 32'h0000_00FF;
  endfunction

  task automatic apb_xfer(input logic wr, input logic [2:0] a, input logic [31:0] wd,
                          output logic [31:0] rd);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= a;
    cfg_pwdata  <= wd;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_reg(input logic idx, input logic [31:0] want);
    logic [31:0] rd;
    apb_xfer(1'b0, {idx, 2'b00}, 32'd0, rd);
    if ((rd & field_mask(idx)) !== want) begin
      errors++;
      $display("%0t: register %0d expected %h got %h", $time, idx, want,
               rd & field_mask(idx));
    end
  endtask

  task automatic program_reg(input logic idx, input int v);
    logic [31:0] m;
    logic [31:0] rd;
    m = field_mask(idx);
    apb_xfer(1'b1, {idx, 2'b00}, ($urandom & ~m) | (32'(v) & m), rd);
    if (idx == dsh_pkg::REG_SIDE_LOG2) cfg_side = v & 15;
    else cfg_spread = v & 255;
    check_reg(idx, 32'(v) & m);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_word(input logic [15:0] w, input int gap, input logic use_typed,
                           input point_t typed_pt, output logic map_done);
    point_t p;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.random_word <= w;
    do @(posedge clk); while (!in_ch.ready);
    p = next_point(w);
    pending_points.push_back(use_typed ? typed_pt : p);
    map_done = p.last;
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [8:0] want,
                             input logic [8:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_points.size() == 0) begin
        errors++;
        $display("%0t: point (%0d,%0d) height %0d with no request outstanding", $time,
                 out_ch.x_pos, out_ch.y_pos, out_ch.height);
      end else begin
        head = pending_points.pop_front();
        check_field("x_pos", head.x, out_ch.x_pos);
        check_field("y_pos", head.y, out_ch.y_pos);
        check_field("height", 9'(head.h), 9'(out_ch.height));
        check_field("last", 9'(head.last), 9'(out_ch.last));
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (sink_mode_left == 0) begin
      steady_sink = ($urandom_range(0, 3) == 0);
      sink_mode_left = $urandom_range(50, 300);
    end else begin
      sink_mode_left--;
    end
    if (stall_left > 0) begin
      stall_left--;
      sink_ready <= 1'b0;
    end else if (steady_sink) begin
      sink_ready <= 1'b1;
    end else if ($urandom_range(0, 99) < 4) begin
      stall_left = $urandom_range(8, 30);
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= ($urandom_range(0, 99) >= 30);
    end
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    plan_row_t plan [PLAN_ROWS];
    logic      map_done;
    int        chunk;
    int        n_sent;
    in_ch.valid       = 1'b0;
    in_ch.random_word = 16'd0;
    // 3x3 map at full spread: offsets and corner words pin every point to 0 or 255
    plan = '{
      '{ROW_SIDE,   16'd1,    1'b0, '0},
      '{ROW_SPREAD, 16'd255,  1'b0, '0},
      '{ROW_POINT,  16'h0000, 1'b1, '{9'd0, 9'd0, 8'h00, 1'b0}},
      '{ROW_POINT,  16'hFFFF, 1'b1, '{9'd2, 9'd0, 8'hFF, 1'b0}},
      '{ROW_POINT,  16'h00FF, 1'b1, '{9'd0, 9'd2, 8'h00, 1'b0}},
      '{ROW_POINT,  16'hFF00, 1'b1, '{9'd2, 9'd2, 8'hFF, 1'b0}},
      '{ROW_POINT,  16'h0000, 1'b1, '{9'd1, 9'd1, 8'h00, 1'b0}},
      '{ROW_POINT,  16'hFFFF, 1'b1, '{9'd1, 9'd0, 8'hFF, 1'b0}},
      '{ROW_POINT,  16'h0000, 1'b1, '{9'd0, 9'd1, 8'h00, 1'b0}},
      '{ROW_POINT,  16'hFFFF, 1'b1, '{9'd2, 9'd1, 8'hFF, 1'b0}},
      '{ROW_POINT,  16'h0000, 1'b1, '{9'd1, 9'd2, 8'h00, 1'b1}},
      // side below range saturates, zero spread gives plain means
      '{ROW_SIDE,   16'd0,    1'b0, '0},
      '{ROW_SPREAD, 16'd0,    1'b0, '0},
      '{ROW_POINT,  16'h1234, 1'b0, '0},
      '{ROW_POINT,  16'hABCD, 1'b0, '0},
      '{ROW_POINT,  16'h5A5A, 1'b0, '0},
      '{ROW_POINT,  16'hA5A5, 1'b0, '0},
      '{ROW_POINT,  16'h8000, 1'b0, '0},
      '{ROW_POINT,  16'h7FFF, 1'b0, '0},
      '{ROW_POINT,  16'h0001, 1'b0, '0},
      '{ROW_POINT,  16'hFFFE, 1'b0, '0},
      '{ROW_POINT,  16'h4321, 1'b0, '0}
    };

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    check_reg(dsh_pkg::REG_SIDE_LOG2, 32'd8);
    check_reg(dsh_pkg::REG_START_SPREAD, 32'd128);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_SIDE: begin
          wait_idle();
          program_reg(dsh_pkg::REG_SIDE_LOG2, plan[i].val);
        end
        ROW_SPREAD: begin
          wait_idle();
          program_reg(dsh_pkg::REG_START_SPREAD, plan[i].val);
        end
        default: begin
          send_word(plan[i].val, pick_gap(), plan[i].typed, plan[i].pt, map_done);
        end
      endcase
    end

    // some phases stop mid-map so new settings wait for the next map
    while (items_sent < RANDOM_ITEMS) begin
      wait_idle();
      if ($urandom_range(0, 4) != 0) program_reg(dsh_pkg::REG_SIDE_LOG2, pick_side());
      if ($urandom_range(0, 4) != 0) program_reg(dsh_pkg::REG_START_SPREAD, pick_spread());
      steady_flow = ($urandom_range(0, 3) == 0);
      chunk = ($urandom_range(0, 9) < 7) ? (1 << 20) : $urandom_range(1, 60);
      map_done = 1'b0;
      for (n_sent = 0; n_sent < chunk && !map_done; n_sent++) begin
        send_word(pick_word(), pick_gap(), 1'b0, '0, map_done);
      end
    end
    while (!(scan_phase == dsh_pkg::PH_CORNER && col == 0 && row == 0)) begin
      send_word(pick_word(), pick_gap(), 1'b0, '0, map_done);
    end

    // full-size map, side above range saturates
    wait_idle();
    program_reg(dsh_pkg::REG_SIDE_LOG2, 15);
    program_reg(dsh_pkg::REG_START_SPREAD, 255);
    steady_flow = 1'b0;
    repeat (BIG_MAP_ITEMS) send_word(pick_word(), pick_gap(), 1'b0, '0, map_done);

    in_ch.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/dsh_pkg.sv
hdl/dsh_in_if.sv
hdl/dsh_out_if.sv
hdl/diamond_square_heightmap_top.sv
bench/tb_diamond_square_heightmap_top.sv
